[rtl/core/sfss_pkg.sv]
// shared types, codes and constants of the sensor frame to seven-segment core
// no dependencies; compiled first
package sfss_pkg;

	// input operation codes
	typedef enum logic [1:0] {
		OP_BYTE   = 2'd0,
		OP_TICK   = 2'd1,
		OP_BUTTON = 2'd2
	} op_t;

	// configuration register indexes
	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_TEMP   = 1'b1;

	localparam logic [5:0] PERIOD_RESET = 6'd60;
	localparam logic [5:0] TEMP_RESET   = 6'd40;

	// frame masks
	localparam logic [15:0] TEMP_MASK = 16'hFFFC;
	localparam logic [15:0] HUM_MASK  = 16'hFFFE;

	// fixed point conversion, results are (raw * scale - offset) / 2^16
	localparam logic [14:0]        TEMP_SCALE  = 15'd17572;
	localparam logic signed [31:0] TEMP_OFFSET = 32'sd307036160;
	localparam logic [6:0]         HUM_SCALE   = 7'd125;
	localparam logic signed [23:0] HUM_OFFSET  = 24'sd393216;

	// lowest temperature that is still shown
	localparam logic signed [14:0] TEMP_SHOW_MIN = -15'sd4675;

	// floor(m / 100) = (m * 5243) >> 19 for m below 43690
	localparam logic [12:0] DIV100_RECIP = 13'd5243;

	localparam logic [6:0] SEG_MINUS = 7'h40;

	// one queued item: state after the beat was applied
	typedef struct packed {
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
		logic [5:0]  tick_count;
		logic        started;
	} snap_t;

	typedef struct packed {
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
	} bcd3_t;

	// active-high segment pattern of one decimal digit
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [6:0] p;
		begin
			case (d)
				4'd0: p = 7'h3F;
				4'd1: p = 7'h06;
				4'd2: p = 7'h5B;
				4'd3: p = 7'h4F;
				4'd4: p = 7'h66;
				4'd5: p = 7'h6D;
				4'd6: p = 7'h7D;
				4'd7: p = 7'h07;
				4'd8: p = 7'h7F;
				4'd9: p = 7'h6F;
				default: p = 7'h00;
			endcase
			return p;
		end
	endfunction

	// 8-bit binary to three decimal digits by parallel compares
	function automatic bcd3_t bcd8(input logic [7:0] x);
		bcd3_t      b;
		logic [7:0] r;
		logic [7:0] tens10;
		begin
			if (x >= 8'd200) begin
				b.hundreds = 4'd2;
				r = x - 8'd200;
			end else if (x >= 8'd100) begin
				b.hundreds = 4'd1;
				r = x - 8'd100;
			end else begin
				b.hundreds = 4'd0;
				r = x;
			end
			b.tens = 4'd0;
			for (int k = 1; k < 10; k++) begin
				if (r >= 8'(k * 10)) b.tens = 4'(k);
			end
			tens10 = {1'b0, b.tens, 3'b000} + {3'b000, b.tens, 1'b0};
			b.ones = 4'(r - tens10);
			return b;
		end
	endfunction

endpackage

[rtl/core/sfss_in_if.sv]
// input channel: operation code and serial byte with valid/ready
// no dependencies
interface sfss_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_byte;

	modport source(output valid, output op, output data_byte, input ready);
	modport sink(input valid, input op, input data_byte, output ready);
endinterface

[rtl/core/sfss_out_if.sv]
// result channel: segment patterns, masks and current readings with valid/ready
// no dependencies
interface sfss_out_if;
	logic              valid;
	logic              ready;
	logic [3:0]        digit_enable;
	logic [6:0]        seg_first;
	logic [6:0]        seg_second;
	logic [6:0]        seg_third;
	logic [6:0]        seg_fourth;
	logic [3:0]        point_mask;
	logic              showing_humidity;
	logic signed [14:0] temp_centi;
	logic signed [7:0]  humidity_pct;

	modport source(
		output valid, output digit_enable, output seg_first, output seg_second,
		output seg_third, output seg_fourth, output point_mask,
		output showing_humidity, output temp_centi, output humidity_pct,
		input ready
	);
	modport sink(
		input valid, input digit_enable, input seg_first, input seg_second,
		input seg_third, input seg_fourth, input point_mask,
		input showing_humidity, input temp_centi, input humidity_pct,
		output ready
	);
endinterface

[rtl/core/sfss_front.sv]
// front end: takes input beats, assembles frames, counts ticks, queues snapshots
// depends on sfss_pkg and sfss_in_if
module sfss_front (
	input  logic           clk,
	input  logic           arst_n,
	sfss_in_if.sink        in_ch,
	input  logic [5:0]     period_seconds,
	input  logic           q_full,
	output logic           push,
	output sfss_pkg::snap_t push_data
);
	import sfss_pkg::*;

	logic [1:0]  frame_index_q, frame_index_d;
	logic [23:0] partial_q, partial_d;
	logic [15:0] temp_raw_q, temp_raw_d;
	logic [15:0] hum_raw_q, hum_raw_d;
	logic [5:0]  tick_q, tick_d;
	logic        started_q, started_d;
	logic [5:0]  tick_inc;
	logic [31:0] word;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	assign tick_inc = tick_q + 6'd1;
	assign word     = {partial_q, in_ch.data_byte};

	// next state for the accepted beat
	always_comb begin
		frame_index_d = frame_index_q;
		partial_d     = partial_q;
		temp_raw_d    = temp_raw_q;
		hum_raw_d     = hum_raw_q;
		tick_d        = tick_q;
		started_d     = started_q;
		case (in_ch.op)
			OP_BYTE: begin
				if (frame_index_q == 2'd3) begin
					temp_raw_d    = word[31:16] & TEMP_MASK;
					hum_raw_d     = word[15:0] & HUM_MASK;
					partial_d     = '0;
					frame_index_d = 2'd0;
				end else begin
					partial_d     = {partial_q[15:0], in_ch.data_byte};
					frame_index_d = frame_index_q + 2'd1;
				end
			end
			OP_TICK: begin
				if (started_q) tick_d = (tick_inc >= period_seconds) ? 6'd0 : tick_inc;
			end
			OP_BUTTON: begin
				started_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// snapshot carries the state after this beat
	assign push_data.temp_raw   = temp_raw_d;
	assign push_data.hum_raw    = hum_raw_d;
	assign push_data.tick_count = tick_d;
	assign push_data.started    = started_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_index_q <= '0;
			partial_q     <= '0;
			temp_raw_q    <= '0;
			hum_raw_q     <= '0;
			tick_q        <= '0;
			started_q     <= 1'b0;
		end else if (push) begin
			frame_index_q <= frame_index_d;
			partial_q     <= partial_d;
			temp_raw_q    <= temp_raw_d;
			hum_raw_q     <= hum_raw_d;
			tick_q        <= tick_d;
			started_q     <= started_d;
		end
	end

endmodule

[rtl/core/sfss_queue.sv]
// short first-in first-out queue of snapshots between front and back end
// depends on sfss_pkg
module sfss_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfss_pkg::snap_t push_data,
	output logic            full,
	input  logic            pop,
	output sfss_pkg::snap_t pop_data,
	output logic            empty
);
	import sfss_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	snap_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/sfss_back.sv]
// back end: converts queued readings, splits digits, lays out the display
// depends on sfss_pkg and sfss_out_if
module sfss_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  sfss_pkg::snap_t q_data,
	output logic            q_pop,
	input  logic [5:0]      period_seconds,
	input  logic [5:0]      temp_seconds,
	sfss_out_if.source      out_ch
);
	import sfss_pkg::*;

	typedef enum logic [2:0] {
		TC_BIG,
		TC_THOUSANDS,
		TC_POSITIVE,
		TC_NEG_SMALL,
		TC_NEG_BIG
	} tclass_t;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4, en_out;
	logic out_valid_q;

	// stage 1: products
	logic [30:0] tprod_s1;
	logic [22:0] hprod_s1;
	logic [5:0]  tick_s1;
	logic        started_s1;

	// stage 2: signed readings and magnitudes
	logic signed [31:0] tnum;
	logic [31:0]        tabs;
	logic [13:0]        tmag_d;
	logic signed [23:0] hnum;
	logic [23:0]        habs;
	logic [6:0]         hmag_d;
	logic signed [14:0] t_s2;
	logic [13:0]        tmag_s2;
	logic signed [7:0]  h_s2;
	logic [6:0]         hmag_s2;
	logic [5:0]         tick_s2;
	logic               started_s2;

	// stage 3: mode, class and reciprocal product
	tclass_t            tclass_d;
	logic signed [14:0] t_s3;
	logic [13:0]        tmag_s3;
	logic signed [7:0]  h_s3;
	logic [6:0]         hmag_s3;
	logic [26:0]        prod_s3;
	tclass_t            tclass_s3;
	logic               show_t_s3;
	logic               show_h_s3;

	// stage 4: decimal digits
	logic [7:0]         hi;
	logic [14:0]        hi100;
	logic [6:0]         lo;
	bcd3_t              bt_s4;
	bcd3_t              bl_s4;
	bcd3_t              bh_s4;
	logic signed [14:0] t_s4;
	logic signed [7:0]  h_s4;
	tclass_t            tclass_s4;
	logic               show_t_s4;
	logic               show_h_s4;

	// layout
	logic [3:0] en_d, pt_d;
	logic       hum_d;
	logic [6:0] sg0, sg1, sg2, sg3;

	// output register
	logic [3:0]         en_q, pt_q;
	logic               hum_q;
	logic [6:0]         sg0_q, sg1_q, sg2_q, sg3_q;
	logic signed [14:0] t_q;
	logic signed [7:0]  h_q;

	// stall chain from the output register back to the queue
	assign en_out = !out_valid_q || out_ch.ready;
	assign en_s4  = !v_s4 || en_out;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign q_pop  = en_s1 && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= !q_empty;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_out) out_valid_q <= v_s4;
		end
	end

	// stage 1: scale raw words
	always_ff @(posedge clk) begin
		if (en_s1) begin
			tprod_s1   <= 31'(q_data.temp_raw) * 31'(TEMP_SCALE);
			hprod_s1   <= 23'(q_data.hum_raw) * 23'(HUM_SCALE);
			tick_s1    <= q_data.tick_count;
			started_s1 <= q_data.started;
		end
	end

	// stage 2: subtract offset, divide by 2^16 truncating toward zero
	assign tnum   = $signed({1'b0, tprod_s1}) - TEMP_OFFSET;
	assign tabs   = tnum[31] ? 32'(-tnum) : 32'(tnum);
	assign tmag_d = tabs[29:16];
	assign hnum   = $signed({1'b0, hprod_s1}) - HUM_OFFSET;
	assign habs   = hnum[23] ? 24'(-hnum) : 24'(hnum);
	assign hmag_d = habs[22:16];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			tmag_s2    <= tmag_d;
			t_s2       <= tnum[31] ? -$signed({1'b0, tmag_d}) : $signed({1'b0, tmag_d});
			hmag_s2    <= hmag_d;
			h_s2       <= hnum[23] ? -$signed({1'b0, hmag_d}) : $signed({1'b0, hmag_d});
			tick_s2    <= tick_s1;
			started_s2 <= started_s1;
		end
	end

	// stage 3: temperature layout class
	always_comb begin
		if (t_s2 >= 15'sd10000) tclass_d = TC_BIG;
		else if (t_s2 >= 15'sd1000) tclass_d = TC_THOUSANDS;
		else if (t_s2 >= 15'sd0) tclass_d = TC_POSITIVE;
		else if (t_s2 > -15'sd1000) tclass_d = TC_NEG_SMALL;
		else tclass_d = TC_NEG_BIG;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3   <= 27'(tmag_s2) * 27'(DIV100_RECIP);
			tclass_s3 <= tclass_d;
			show_t_s3 <= started_s2 && (tick_s2 < temp_seconds) && (t_s2 >= TEMP_SHOW_MIN);
			show_h_s3 <= started_s2 && (tick_s2 >= temp_seconds) && (tick_s2 < period_seconds);
			t_s3      <= t_s2;
			tmag_s3   <= tmag_s2;
			h_s3      <= h_s2;
			hmag_s3   <= hmag_s2;
		end
	end

	// stage 4: split magnitude into hundreds part and remainder, then digits
	assign hi    = prod_s3[26:19];
	assign hi100 = 15'({hi, 6'b0}) + 15'({hi, 5'b0}) + 15'({hi, 2'b0});
	assign lo    = 7'(15'(tmag_s3) - hi100);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			bt_s4     <= bcd8(hi);
			bl_s4     <= bcd8({1'b0, lo});
			bh_s4     <= bcd8({1'b0, hmag_s3});
			t_s4      <= t_s3;
			h_s4      <= h_s3;
			tclass_s4 <= tclass_s3;
			show_t_s4 <= show_t_s3;
			show_h_s4 <= show_h_s3;
		end
	end

	// display layout; digit weights 10^4..10^2 in bt_s4, 10^1..10^0 in bl_s4
	always_comb begin
		en_d  = '0;
		pt_d  = '0;
		hum_d = 1'b0;
		sg0   = '0;
		sg1   = '0;
		sg2   = '0;
		sg3   = '0;
		if (show_t_s4) begin
			case (tclass_s4)
				TC_BIG: begin
					sg0 = seg_of(bt_s4.hundreds);
					sg1 = seg_of(bt_s4.tens);
					sg2 = seg_of(bt_s4.ones);
					sg3 = seg_of(bl_s4.tens);
					en_d = 4'hF;
					pt_d = 4'h4;
				end
				TC_THOUSANDS: begin
					sg0 = seg_of(bt_s4.tens);
					sg1 = seg_of(bt_s4.ones);
					sg2 = seg_of(bl_s4.tens);
					sg3 = seg_of(bl_s4.ones);
					en_d = 4'hF;
					pt_d = 4'h2;
				end
				TC_POSITIVE: begin
					sg0 = seg_of(bt_s4.ones);
					sg1 = seg_of(bl_s4.tens);
					sg2 = seg_of(bl_s4.ones);
					en_d = 4'h7;
					pt_d = 4'h1;
				end
				TC_NEG_SMALL: begin
					sg0 = SEG_MINUS;
					sg1 = seg_of(bt_s4.ones);
					sg2 = seg_of(bl_s4.tens);
					sg3 = seg_of(bl_s4.ones);
					en_d = 4'hF;
					pt_d = 4'h2;
				end
				default: begin
					sg0 = SEG_MINUS;
					sg1 = seg_of(bt_s4.tens);
					sg2 = seg_of(bt_s4.ones);
					sg3 = seg_of(bl_s4.tens);
					en_d = 4'hF;
					pt_d = 4'h4;
				end
			endcase
		end else if (show_h_s4) begin
			hum_d = 1'b1;
			if (h_s4 >= 8'sd100) begin
				sg0  = seg_of(4'd1);
				sg1  = seg_of(4'd0);
				sg2  = seg_of(4'd0);
				en_d = 4'h7;
			end else if (h_s4 >= 8'sd10) begin
				sg0  = seg_of(bh_s4.tens);
				sg1  = seg_of(bh_s4.ones);
				en_d = 4'h3;
			end else if (h_s4 >= 8'sd0) begin
				sg0  = seg_of(bh_s4.ones);
				en_d = 4'h1;
			end else begin
				sg0  = seg_of(4'd0);
				en_d = 4'h1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en_out) begin
			en_q  <= en_d;
			pt_q  <= pt_d;
			hum_q <= hum_d;
			sg0_q <= sg0;
			sg1_q <= sg1;
			sg2_q <= sg2;
			sg3_q <= sg3;
			t_q   <= t_s4;
			h_q   <= h_s4;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.digit_enable     = en_q;
	assign out_ch.seg_first        = sg0_q;
	assign out_ch.seg_second       = sg1_q;
	assign out_ch.seg_third        = sg2_q;
	assign out_ch.seg_fourth       = sg3_q;
	assign out_ch.point_mask       = pt_q;
	assign out_ch.showing_humidity = hum_q;
	assign out_ch.temp_centi       = t_q;
	assign out_ch.humidity_pct     = h_q;

endmodule

[rtl/core/sensor_frame_to_seven_segment_core.sv]
// top level: sensor frame to seven-segment display core
// a result is valid once its accepted input beat has passed the snapshot queue, back end and output register
// throughput: one beat per cycle unless the queue is full; the back end is a 4-stage pipeline plus output register
// input ready drops only when the snapshot queue (QUEUE_DEPTH entries) is full
// reset (arst_n low): frame, tick count and started flag cleared, queue empty, no result valid,
// period_seconds 60 and temp_seconds 40
module sensor_frame_to_seven_segment_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	sfss_in_if.sink    in_ch,
	sfss_out_if.source out_ch,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data
);
	import sfss_pkg::*;

	logic [5:0] period_q;
	logic [5:0] temp_q;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	snap_t      q_in;
	snap_t      q_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			temp_q   <= TEMP_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_PERIOD: period_q <= cfg_data;
				CFG_TEMP:   temp_q   <= cfg_data;
				default:    period_q <= period_q;
			endcase
		end
	end

	sfss_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.period_seconds (period_q),
		.q_full         (q_full),
		.push           (q_push),
		.push_data      (q_in)
	);

	sfss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	sfss_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_data         (q_out),
		.q_pop          (q_pop),
		.period_seconds (period_q),
		.temp_seconds   (temp_q),
		.out_ch         (out_ch)
	);

	// front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("snapshot pushed into full queue");

	// a blank beat has nothing lit
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.digit_enable == 4'h0) |->
		(out_ch.seg_first == 7'h00 && out_ch.seg_second == 7'h00 &&
		out_ch.seg_third == 7'h00 && out_ch.seg_fourth == 7'h00 &&
		out_ch.point_mask == 4'h0 && !out_ch.showing_humidity))
		else $error("blank beat with lit segments");

	// humidity layouts use no points and never the fourth digit
	a_hum_layout: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.showing_humidity) |->
		(out_ch.point_mask == 4'h0 && !out_ch.digit_enable[3] && out_ch.digit_enable[0]))
		else $error("bad humidity layout");

endmodule
